// ===== rtl/numask_pkg.sv =====
// Shared types, constants and unit-word tables for the number/unit masker.
// Used by numask_ctrl, numask_dp and number_unit_masker_unit; depends on nothing.
package numask_pkg;

  localparam int PEND_DEPTH = 32;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);
  localparam int PEND_CW    = $clog2(PEND_DEPTH + 1);

  localparam int NUM_UNITS   = 15;
  localparam int UNIT_MAXLEN = 10;

  localparam logic [15:0] CAP_RESET = 16'd256;
  localparam logic [7:0]  CH_HASH   = 8'h23;
  localparam logic [7:0]  CH_NBSP1  = 8'hC2;
  localparam logic [7:0]  CH_NBSP2  = 8'hA0;
  localparam logic [7:0]  CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_GAP,
    MODE_GAP_C2,
    MODE_WORD,
    MODE_PASS
  } mode_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PROC,
    ST_FL_RD,
    ST_FL_WR,
    ST_FIN,
    ST_TERM
  } step_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_CUR,
    EMIT_HASH,
    EMIT_PEND,
    EMIT_TERM
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  store;
    logic  word_init;
    logic  word_step;
    logic  pend_clear;
    logic  flush_start;
    logic  flush_next;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_last;
    logic is_digit;
    logic is_numch;
    logic is_space;
    logic is_c2;
    logic is_a0;
    logic is_letter;
    logic pend_full;
    logic pend_empty;
    logic flush_last;
    logic unit_hit;
    logic out_free;
  } dp_status_t;

  // Unit words, left-aligned with zero padding on the right.
  function automatic logic [8*UNIT_MAXLEN-1:0] unit_word(input logic [3:0] u);
    logic [8*UNIT_MAXLEN-1:0] w;
    unique case (u)
      4'd0:    w = "kilometers";
      4'd1:    w = {"kilometer", 8'h00};
      4'd2:    w = {"meters", 32'h0};
      4'd3:    w = {"meter", 40'h0};
      4'd4:    w = {"miles", 40'h0};
      4'd5:    w = {"mile", 48'h0};
      4'd6:    w = {"yards", 40'h0};
      4'd7:    w = {"yard", 48'h0};
      4'd8:    w = {"feet", 48'h0};
      4'd9:    w = {"foot", 48'h0};
      4'd10:   w = {"km", 64'h0};
      4'd11:   w = {"mi", 64'h0};
      4'd12:   w = {"ft", 64'h0};
      4'd13:   w = {"yd", 64'h0};
      4'd14:   w = {"m", 72'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] unit_len(input logic [3:0] u);
    logic [3:0] n;
    unique case (u)
      4'd0:                         n = 4'd10;
      4'd1:                         n = 4'd9;
      4'd2:                         n = 4'd6;
      4'd3, 4'd4, 4'd6:             n = 4'd5;
      4'd5, 4'd7, 4'd8, 4'd9:       n = 4'd4;
      4'd10, 4'd11, 4'd12, 4'd13:   n = 4'd2;
      4'd14:                        n = 4'd1;
      default:                      n = 4'd0;
    endcase
    return n;
  endfunction

  // Character k of unit u, zero beyond the end of the word.
  function automatic logic [7:0] unit_char(input logic [3:0] u, input logic [3:0] k);
    logic [8*UNIT_MAXLEN-1:0] w;
    logic [7:0]               c;
    w = unit_word(u);
    c = 8'h00;
    for (int i = 0; i < UNIT_MAXLEN; i++) begin
      if (k == 4'(i)) c = w[8*(UNIT_MAXLEN-1-i) +: 8];
    end
    return c;
  endfunction

endpackage

// ===== rtl/numask_ctrl.sv =====
// Sequencer of the number/unit masker: parse mode and per-word step control.
// Depends on numask_pkg; drives numask_dp through dp_cmd_t and reads dp_status_t.
module numask_ctrl
  import numask_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  step_t step, step_next;
  mode_t mode, mode_next;
  logic  ret_term, ret_term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= ST_TAKE;
      mode     <= MODE_IDLE;
      ret_term <= 1'b0;
    end else begin
      step     <= step_next;
      mode     <= mode_next;
      ret_term <= ret_term_next;
    end
  end

  always_comb begin
    logic  done;
    logic  do_flush;
    logic  flush_term;
    mode_t flush_mode;

    step_next     = step;
    mode_next     = mode;
    ret_term_next = ret_term;
    cmd           = '0;
    cmd.emit      = EMIT_NONE;
    in_ready      = 1'b0;
    done          = 1'b0;
    do_flush      = 1'b0;
    flush_term    = 1'b0;
    flush_mode    = MODE_IDLE;

    unique case (step)
      ST_TAKE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_next = ST_PROC;
        end
      end

      ST_PROC: begin
        if (st.is_zero) begin
          step_next = ST_FIN;
        end else begin
          unique case (mode)
            MODE_IDLE: begin
              if (st.is_digit) begin
                cmd.store = 1'b1;
                mode_next = MODE_NUM;
                done      = 1'b1;
              end else if (st.out_free) begin
                cmd.emit = EMIT_CUR;
                done     = 1'b1;
              end
            end
            MODE_NUM, MODE_GAP: begin
              if (mode == MODE_NUM && st.is_numch) begin
                if (!st.pend_full) begin
                  cmd.store = 1'b1;
                  done      = 1'b1;
                end else begin
                  do_flush   = 1'b1;
                  flush_mode = MODE_PASS;
                end
              end else if (st.is_space || st.is_c2 || st.is_letter) begin
                if (!st.pend_full) begin
                  cmd.store = 1'b1;
                  done      = 1'b1;
                  if (st.is_letter) begin
                    cmd.word_init = 1'b1;
                    mode_next     = MODE_WORD;
                  end else if (st.is_c2) begin
                    mode_next = MODE_GAP_C2;
                  end else begin
                    mode_next = MODE_GAP;
                  end
                end else begin
                  do_flush = 1'b1;
                end
              end else begin
                do_flush = 1'b1;
              end
            end
            MODE_GAP_C2: begin
              if (st.is_a0 && !st.pend_full) begin
                cmd.store = 1'b1;
                mode_next = MODE_GAP;
                done      = 1'b1;
              end else begin
                do_flush = 1'b1;
              end
            end
            MODE_WORD: begin
              if (st.is_letter) begin
                if (!st.pend_full) begin
                  cmd.store     = 1'b1;
                  cmd.word_step = 1'b1;
                  done          = 1'b1;
                end else begin
                  do_flush = 1'b1;
                end
              end else if (st.unit_hit) begin
                // Unit recognised: the whole pending run collapses to one mark,
                // then the current byte is looked at again as ordinary text.
                if (st.out_free) begin
                  cmd.emit       = EMIT_HASH;
                  cmd.pend_clear = 1'b1;
                  mode_next      = MODE_IDLE;
                end
              end else begin
                do_flush = 1'b1;
              end
            end
            MODE_PASS: begin
              if (st.is_numch) begin
                if (st.out_free) begin
                  cmd.emit = EMIT_CUR;
                  done     = 1'b1;
                end
              end else begin
                mode_next = MODE_IDLE;
              end
            end
            default: mode_next = MODE_IDLE;
          endcase
          if (done) step_next = st.is_last ? ST_FIN : ST_TAKE;
        end
      end

      ST_FL_RD: step_next = ST_FL_WR;

      ST_FL_WR: begin
        if (st.out_free) begin
          cmd.emit       = EMIT_PEND;
          cmd.flush_next = 1'b1;
          if (st.flush_last) begin
            cmd.pend_clear = 1'b1;
            step_next      = ret_term ? ST_TERM : ST_PROC;
          end else begin
            step_next = ST_FL_RD;
          end
        end
      end

      ST_FIN: begin
        if (mode == MODE_WORD && st.unit_hit) begin
          if (st.out_free) begin
            cmd.emit       = EMIT_HASH;
            cmd.pend_clear = 1'b1;
            step_next      = ST_TERM;
          end
        end else begin
          do_flush   = 1'b1;
          flush_term = 1'b1;
        end
      end

      ST_TERM: begin
        if (st.out_free) begin
          cmd.emit       = EMIT_TERM;
          cmd.pend_clear = 1'b1;
          mode_next      = MODE_IDLE;
          step_next      = ST_TAKE;
        end
      end

      default: step_next = ST_TAKE;
    endcase

    if (do_flush) begin
      mode_next     = flush_mode;
      ret_term_next = flush_term;
      if (st.pend_empty) begin
        step_next = flush_term ? ST_TERM : ST_PROC;
      end else begin
        cmd.flush_start = 1'b1;
        step_next       = ST_FL_RD;
      end
    end
  end

endmodule

// ===== rtl/numask_dp.sv =====
// Datapath of the number/unit masker: current byte, pending store, unit matcher,
// output limit and output register. Depends on numask_pkg; commanded by numask_ctrl.
module numask_dp
  import numask_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_valid,
  input  logic        out_ready,
  input  dp_cmd_t     cmd,
  output dp_status_t  st
);

  logic [15:0]          cap;
  logic [7:0]           cur_byte;
  logic                 cur_last;
  logic [7:0]           pend_mem [PEND_DEPTH];
  logic [7:0]           rd_data;
  logic [PEND_CW-1:0]   pend_count;
  logic [PEND_CW-1:0]   flush_idx;
  logic [15:0]          output_count;
  logic [NUM_UNITS-1:0] match_mask, match_mask_next;
  logic [3:0]           word_len;
  logic [7:0]           cur_lower;
  logic [15:0]          cap_eff;
  logic                 room;
  logic [7:0]           emit_byte;
  logic                 hit;

  assign cur_lower = cur_byte | 8'h20;
  assign cap_eff   = (cap == 16'd0) ? 16'd1 : cap;
  assign room      = ({1'b0, output_count} + 17'd1) < {1'b0, cap_eff};

  always_comb begin
    hit             = 1'b0;
    match_mask_next = match_mask;
    for (int u = 0; u < NUM_UNITS; u++) begin
      if (match_mask[u] && word_len == unit_len(4'(u))) hit = 1'b1;
      if (cmd.word_init) begin
        match_mask_next[u] = (unit_char(4'(u), 4'd0) == cur_lower);
      end else if (cmd.word_step) begin
        match_mask_next[u] = match_mask[u] && (unit_char(4'(u), word_len) == cur_lower);
      end
    end
  end

  always_comb begin
    unique case (cmd.emit)
      EMIT_CUR:  emit_byte = cur_byte;
      EMIT_HASH: emit_byte = CH_HASH;
      EMIT_PEND: emit_byte = rd_data;
      default:   emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    st.is_zero    = (cur_byte == 8'h00);
    st.is_last    = cur_last;
    st.is_digit   = (cur_byte >= "0") && (cur_byte <= "9");
    st.is_numch   = st.is_digit || (cur_byte == ",") || (cur_byte == ".");
    st.is_space   = (cur_byte == CH_SPACE);
    st.is_c2      = (cur_byte == CH_NBSP1);
    st.is_a0      = (cur_byte == CH_NBSP2);
    st.is_letter  = ((cur_byte >= "a") && (cur_byte <= "z")) ||
                    ((cur_byte >= "A") && (cur_byte <= "Z"));
    st.pend_full  = (pend_count == PEND_CW'(PEND_DEPTH));
    st.pend_empty = (pend_count == '0);
    st.flush_last = ((flush_idx + PEND_CW'(1)) == pend_count);
    st.unit_hit   = hit;
    st.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= in_byte;
      cur_last <= in_last;
    end
    if (cmd.store) pend_mem[pend_count[PEND_AW-1:0]] <= cur_byte;
    rd_data <= pend_mem[flush_idx[PEND_AW-1:0]];
    if (cmd.word_init || cmd.word_step) begin
      match_mask <= match_mask_next;
      if (cmd.word_init)          word_len <= 4'd1;
      else if (word_len != 4'hF)  word_len <= word_len + 4'd1;
    end
    if (cmd.emit != EMIT_NONE && (room || cmd.emit == EMIT_TERM)) begin
      out_byte <= emit_byte;
      out_last <= (cmd.emit == EMIT_TERM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= CAP_RESET;
      pend_count   <= '0;
      flush_idx    <= '0;
      output_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) cap <= cfg_wdata;
      if (cmd.pend_clear)  pend_count <= '0;
      else if (cmd.store)  pend_count <= pend_count + PEND_CW'(1);
      if (cmd.flush_start)     flush_idx <= '0;
      else if (cmd.flush_next) flush_idx <= flush_idx + PEND_CW'(1);
      if (cmd.emit == EMIT_TERM) begin
        output_count <= '0;
        out_valid    <= 1'b1;
      end else if (cmd.emit != EMIT_NONE && room) begin
        output_count <= output_count + 16'd1;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/number_unit_masker_unit.sv =====
// Top level of the number/unit masker: stream ports, configuration port and
// the controller/datapath pair. Depends on numask_pkg, numask_ctrl and numask_dp.
//
//   Channel   Direction  Handshake               Contents
//   s_axis    in         tvalid/tready           tdata[7:0] in_byte, tlast in_last
//   m_axis    out        tvalid/tready           tdata[7:0] out_byte, tlast out_last
//   cfg       in         cfg_we (no wait)        cfg_wdata[15:0] output_capacity
//
// An input word that is stored or copied straight through is taken in ST_TAKE
// and parsed in ST_PROC. Each pending byte flushed passes through ST_FL_RD and
// ST_FL_WR by the registered read port of the pending store, after which the
// word that ended the run takes one more parse step; a recognised unit also
// costs one more parse step. The end of a string, by tlast or by a zero word,
// passes ST_FIN, to resolve an open number, and ST_TERM for the terminator.
// Reset (rst, synchronous) returns the parser to idle copying with an empty
// pending store and a capacity of 256; the store itself is not cleared.
// A stalled output side holds the sequencer; the single output register lets
// the next word be emitted in the cycle in which the previous one is taken.
module number_unit_masker_unit
  import numask_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  // Output words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  // Output capacity register.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // The controller sequences the parse of one word at a time; all byte
  // classification, storage and counting lives in the datapath.
  numask_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  numask_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for number_unit_masker_unit: streams text strings in,
// predicts the rewritten text and compares every output word against it.
// Depends on numask_pkg and number_unit_masker_unit.
`timescale 1ns / 100ps

module tb;
  import numask_pkg::*;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam int         SETTLE_CYCLES = 120;
  localparam int         IDLE_LIMIT    = 3000;
  localparam int         PHASE_WORDS   = 4;
  localparam int         NUM_PHASES    = 7;

  // One output word as the block presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_word_t;

  // Kinds of text fragment that the random strings are made of.
  typedef enum int {
    TK_UNIT,
    TK_NEAR,
    TK_BROKEN_GAP,
    TK_NOISE,
    TK_TEXT,
    TK_LONG_NUM,
    TK_LONG_GAP,
    TK_LONG_WORD
  } token_kind_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKS
  } rx_pattern_t;

  // Scoreboard: a behavioural copy of the masker that turns each accepted input
  // word into the output words it should cause, and a queue of those words that
  // the monitor checks against, oldest first.
  class text_mask_checker;
    mode_t        mode;
    logic [7:0]   held[PEND_DEPTH];
    int           held_n;
    int           word_at;
    int           out_n;
    logic [15:0]  capacity;
    text_word_t   masked_text[$];
    int           errors;

    function new();
      capacity = CAP_RESET;
      errors   = 0;
      clear_string();
    endfunction

    static function string unit_name(int u);
      case (u)
        0:       return "kilometers";
        1:       return "kilometer";
        2:       return "meters";
        3:       return "meter";
        4:       return "miles";
        5:       return "mile";
        6:       return "yards";
        7:       return "yard";
        8:       return "feet";
        9:       return "foot";
        10:      return "km";
        11:      return "mi";
        12:      return "ft";
        13:      return "yd";
        default: return "m";
      endcase
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_numch(logic [7:0] b);
      return is_digit(b) || b == "," || b == ".";
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void clear_string();
      mode    = MODE_IDLE;
      held_n  = 0;
      word_at = 0;
      out_n   = 0;
    endfunction

    // Text beyond capacity-1 words is dropped; a capacity of zero acts as one.
    function void emit_text(logic [7:0] b);
      int cap;
      cap = (capacity == 16'd0) ? 1 : int'(capacity);
      if (out_n + 1 < cap) begin
        masked_text.push_back('{data: b, last: 1'b0});
        out_n++;
      end
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) emit_text(held[i]);
      held_n  = 0;
      word_at = 0;
      mode    = MODE_IDLE;
    endfunction

    function bit keep(logic [7:0] b);
      if (held_n >= PEND_DEPTH) return 1'b0;
      held[held_n] = b;
      held_n++;
      return 1'b1;
    endfunction

    // The whole letter run, folded to lower case, must equal one unit word.
    function bit unit_found();
      int         len;
      string      name;
      bit         same;
      logic [7:0] c;
      if (word_at >= held_n) return 1'b0;
      len = held_n - word_at;
      for (int u = 0; u < NUM_UNITS; u++) begin
        name = unit_name(u);
        if (name.len() == len) begin
          same = 1'b1;
          for (int k = 0; k < len; k++) begin
            c = held[word_at + k];
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            if (c != name[k]) same = 1'b0;
          end
          if (same) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Parses one text byte; a byte that ends a state is parsed again in the
    // state that follows.
    function void mask_byte(logic [7:0] b);
      bit again;
      do begin
        again = 1'b0;
        case (mode)
          MODE_NUM: begin
            if (is_numch(b)) begin
              if (!keep(b)) begin
                flush_held();
                mode = MODE_PASS;
                emit_text(b);
              end
            end else if (b == CH_SPACE || b == CH_NBSP1 || is_alpha(b)) begin
              word_at = held_n;
              if (!keep(b)) begin
                flush_held();
                again = 1'b1;
              end else if (is_alpha(b)) begin
                mode = MODE_WORD;
              end else if (b == CH_NBSP1) begin
                mode = MODE_GAP_C2;
              end else begin
                mode = MODE_GAP;
              end
            end else begin
              flush_held();
              again = 1'b1;
            end
          end
          MODE_GAP: begin
            if (b == CH_SPACE || b == CH_NBSP1 || is_alpha(b)) begin
              if (is_alpha(b)) word_at = held_n;
              if (!keep(b)) begin
                flush_held();
                again = 1'b1;
              end else if (b == CH_NBSP1) begin
                mode = MODE_GAP_C2;
              end else if (is_alpha(b)) begin
                mode = MODE_WORD;
              end
            end else begin
              flush_held();
              again = 1'b1;
            end
          end
          MODE_GAP_C2: begin
            if (b == CH_NBSP2 && keep(b)) begin
              mode = MODE_GAP;
            end else begin
              flush_held();
              again = 1'b1;
            end
          end
          MODE_WORD: begin
            if (is_alpha(b)) begin
              if (!keep(b)) begin
                flush_held();
                again = 1'b1;
              end
            end else begin
              if (unit_found()) begin
                held_n  = 0;
                word_at = 0;
                mode    = MODE_IDLE;
                emit_text(CH_HASH);
              end else begin
                flush_held();
              end
              again = 1'b1;
            end
          end
          MODE_PASS: begin
            if (is_numch(b)) begin
              emit_text(b);
            end else begin
              mode  = MODE_IDLE;
              again = 1'b1;
            end
          end
          default: begin
            mode = MODE_IDLE;
            if (is_digit(b)) begin
              held[0] = b;
              held_n  = 1;
              mode    = MODE_NUM;
            end else begin
              emit_text(b);
            end
          end
        endcase
      end while (again);
    endfunction

    // A letter run that ends the string may still be a unit.
    function void end_string();
      if (mode == MODE_WORD && unit_found()) begin
        held_n = 0;
        emit_text(CH_HASH);
      end else begin
        flush_held();
      end
      masked_text.push_back('{data: CH_NUL, last: 1'b1});
      clear_string();
    endfunction

    function void take_word(logic [7:0] b, logic last);
      if (b == CH_NUL) begin
        end_string();
      end else begin
        mask_byte(b);
        if (last) end_string();
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_word(logic [7:0] b, logic last);
      text_word_t want;
      if (masked_text.size() == 0) begin
        report_mismatch($sformatf("unexpected word data %h last %b", b, last));
      end else begin
        want = masked_text.pop_front();
        if (want.data !== b)
          report_mismatch($sformatf("data %h, expected %h", b, want.data));
        if (want.last !== last)
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
      end
    endtask
  endclass

  // Clock, reset and block inputs, all known from time zero.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic [15:0] cfg_wdata     = 16'h0000;

  text_mask_checker text_check;
  logic [7:0]       text_buf[$];
  int               burst_left = 0;
  int               phase_words;
  int               idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  number_unit_masker_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // The receiver switches between stall patterns at random intervals: always
  // ready, a coin toss, one cycle in four, and alternating blocks on and off.
  rx_pattern_t rx_pattern = RX_STEADY;
  int          rx_run     = 0;
  logic [3:0]  rx_tick    = 4'd0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    if (rx_run == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      rx_run     <= $urandom_range(10, 150);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_pattern)
      RX_STEADY: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= (rx_tick[1:0] == 2'd0);
      default:   m_axis_tready <= rx_tick[3];
    endcase
  end

  // Every output word taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      text_check.check_word(m_axis_tdata, m_axis_tlast);
  end

  // The watchdog ends a run in which neither side has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one word, waits for it to be taken and notes it in the scoreboard.
  // The sender works in bursts of random length; a burst may be followed by a
  // gap with tvalid low or run straight into the next one.
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    text_check.take_word(b, last);
    phase_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sends the assembled string with tlast on its final byte.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_word(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Holds the sender until every predicted word has come out, then gives the
  // block time to finish any flush still under way.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (text_check.masked_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_check.capacity = value;
  endtask

  function void add_literal(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // A number: a digit first, then digits with the odd comma or point.
  function void add_number(int n);
    text_buf.push_back(8'($urandom_range(48, 57)));
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       text_buf.push_back(",");
        1:       text_buf.push_back(".");
        default: text_buf.push_back(8'($urandom_range(48, 57)));
      endcase
    end
  endfunction

  function void add_gap(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        text_buf.push_back(CH_SPACE);
      end else begin
        text_buf.push_back(CH_NBSP1);
        text_buf.push_back(CH_NBSP2);
      end
    end
  endfunction

  function void add_letters(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(65, 90)));
      else text_buf.push_back(8'($urandom_range(97, 122)));
    end
  endfunction

  function void add_noise(int n);
    for (int i = 0; i < n; i++) text_buf.push_back(8'($urandom_range(1, 255)));
  endfunction

  // A unit word in mixed case; trim drops its final letters, extra appends some.
  function void add_unit(int trim, int extra);
    string      name;
    logic [7:0] c;
    name = text_check.unit_name($urandom_range(0, NUM_UNITS - 1));
    for (int k = 0; k < name.len() - trim; k++) begin
      c = name[k];
      if ($urandom_range(0, 2) == 0) c = c - 8'd32;
      text_buf.push_back(c);
    end
    add_letters(extra);
  endfunction

  function void add_token(token_kind_t kind);
    logic [7:0] b;
    case (kind)
      TK_UNIT: begin
        add_number($urandom_range(1, 5));
        add_gap($urandom_range(0, 2));
        add_unit(0, 0);
        if ($urandom_range(0, 1) == 0) add_literal(" ");
      end
      TK_NEAR: begin
        add_number($urandom_range(1, 4));
        add_gap($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       add_unit(0, $urandom_range(1, 2));
          1:       add_unit(1, 0);
          default: add_letters($urandom_range(1, 4));
        endcase
        add_noise(1);
      end
      TK_BROKEN_GAP: begin
        // A lead byte of a non-breaking space with the wrong second byte.
        add_number($urandom_range(1, 3));
        if ($urandom_range(0, 1) == 0) add_literal(" ");
        text_buf.push_back(CH_NBSP1);
        b = 8'($urandom_range(1, 255));
        if (b == CH_NBSP2) b = b + 8'd1;
        text_buf.push_back(b);
      end
      TK_NOISE: add_noise($urandom_range(1, 4));
      TK_TEXT: begin
        add_letters($urandom_range(1, 5));
        add_literal(" ");
      end
      TK_LONG_NUM: add_number($urandom_range(PEND_DEPTH + 1, PEND_DEPTH + 4));
      TK_LONG_GAP: begin
        add_number(2);
        for (int i = 0; i < PEND_DEPTH; i++) text_buf.push_back(CH_SPACE);
        add_literal("km");
      end
      default: begin
        add_number(1);
        add_literal(" ");
        add_letters($urandom_range(PEND_DEPTH - 1, PEND_DEPTH + 1));
      end
    endcase
  endfunction

  logic [15:0] caps[NUM_PHASES];
  int          n_strings;
  int          n_tokens;
  int          pick;

  initial begin
    text_check = new();
    caps = '{16'd0, 16'd1, 16'hFFFF, 16'd3, CAP_RESET, 16'd16, 16'($urandom_range(2, 60))};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed strings at the reset capacity: a unit ending the string, a
    // non-breaking space before an upper-case unit, commas and points in a
    // number, a broken non-breaking space, a letter run that is no unit, and a
    // zero byte ending a string on its own.
    phase_words = 0;
    add_literal("5 km");
    send_text();
    add_literal("7");
    text_buf.push_back(CH_NBSP1);
    text_buf.push_back(CH_NBSP2);
    add_literal("MILES.");
    send_text();
    add_literal("9,9.0Ft");
    send_text();
    add_literal("4");
    text_buf.push_back(CH_NBSP1);
    add_literal("A");
    send_text();
    add_literal("2 kmh");
    send_text();
    send_word(8'hFF, 1'b0);
    send_word(CH_NUL, 1'b0);

    // Random strings, one capacity per phase. The block is drained before each
    // register write. The widest capacity gets a number, a gap and a letter
    // run that each overflow the pending store, one string apiece.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_capacity(caps[p]);
      phase_words = 0;
      n_strings   = 0;
      while (phase_words < PHASE_WORDS || (caps[p] == 16'hFFFF && n_strings < 3)) begin
        if (caps[p] == 16'hFFFF && n_strings < 3) begin
          add_token(token_kind_t'(TK_LONG_NUM + n_strings));
        end else begin
          n_tokens = $urandom_range(1, 2);
          for (int t = 0; t < n_tokens; t++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) add_token(TK_UNIT);
            else if (pick < 7) add_token(TK_NEAR);
            else if (pick == 7) add_token(TK_BROKEN_GAP);
            else if (pick == 8) add_token(TK_NOISE);
            else add_token(TK_TEXT);
          end
        end
        send_text();
        n_strings++;
      end
    end

    settle();
    if (text_check.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/numask_pkg.sv
rtl/numask_ctrl.sv
rtl/numask_dp.sv
rtl/number_unit_masker_unit.sv
test/tb.sv
